// ===== rtl/bvst_pkg.sv =====
// Shared types and codes for the busy-vote slot tracker.
// No dependencies; imported by busy_vote_slot_tracker_core.
`timescale 1ns / 1ps
`default_nettype none

package bvst_pkg;

  // Request kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_REGISTER   = 2'd0,
    MODE_UNREGISTER = 2'd1,
    MODE_ADVISE     = 2'd2,
    MODE_NOP        = 2'd3
  } mode_e;

  // Advice values for an advise request; the other codes are rejected.
  localparam logic [1:0] ADVICE_IDLE = 2'd0;
  localparam logic [1:0] ADVICE_BUSY = 2'd1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_UNREG  = 3'd2,
    ST_ADVICE = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned TOTAL_W = 7;

endpackage : bvst_pkg

`default_nettype wire

// ===== rtl/busy_vote_slot_tracker_core.sv =====
// Busy-vote slot tracker: registered and busy marks per client slot with counts.
// Depends on bvst_pkg for request, advice and status codes.
`timescale 1ns / 1ps
`default_nettype none

// An accepted item is held in the input register; when it advances, its result is loaded
// into the result register. The advance is held off while the result register is full
// and its result is not being taken. Throughput: one item per cycle while results are
// taken; the limit is the state loop through the mark registers, the lowest-free-slot
// search and the count update.
// Reset clears every mark and both counts at once; no clearing pass is needed and
// an item may be accepted as soon as reset is released.
module busy_vote_slot_tracker_core
  import bvst_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [SLOT_W-1:0]    slot_i,
  input  wire logic [1:0]           advice_i,

  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic [SLOT_W-1:0]         assigned_slot_o,
  output logic [TOTAL_W-1:0]        busy_total_o,
  output logic [TOTAL_W-1:0]        registered_total_o
);

  // Slot index width and count width follow from the number of slots.
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  // ---------------------------------------------------------------------------
  // Input register. It holds one accepted item until the result register can
  // take its result.
  // ---------------------------------------------------------------------------
  logic              in_valid_q, in_valid_d;
  logic [1:0]        mode_q;
  logic [SLOT_W-1:0] slot_q;
  logic [1:0]        advice_q;
  logic              advance;

  // The item in the input register is processed in the cycle in which the
  // result register is empty or is being emptied.
  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q   <= mode_i;
      slot_q   <= slot_i;
      advice_q <= advice_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracker state: one registered mark and one busy mark per slot, and the
  // number of marks of each kind that are set.
  // ---------------------------------------------------------------------------
  logic [SLOTS-1:0] reg_marks_q, reg_marks_d;
  logic [SLOTS-1:0] busy_marks_q, busy_marks_d;
  logic [CNT_W-1:0] reg_cnt_q, reg_cnt_d;
  logic [CNT_W-1:0] busy_cnt_q, busy_cnt_d;

  // Lowest slot whose registered mark is clear. The scan runs from the top so
  // that the lowest free slot is the last one to be taken.
  logic [IDX_W-1:0] free_idx;
  logic             any_free;

  assign any_free = ~&reg_marks_q;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!reg_marks_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // The request's slot must lie below the slot count before it may be used as
  // an index.
  logic             in_range;
  logic [IDX_W-1:0] idx;

  assign in_range = ({1'b0, slot_q} < (SLOT_W + 1)'(SLOTS));
  assign idx      = slot_q[IDX_W-1:0];

  status_e           status_d;
  logic [SLOT_W-1:0] given_d;

  always_comb begin
    reg_marks_d  = reg_marks_q;
    busy_marks_d = busy_marks_q;
    reg_cnt_d    = reg_cnt_q;
    busy_cnt_d   = busy_cnt_q;
    status_d     = ST_OK;
    given_d      = slot_q;

    case (mode_q)
      MODE_REGISTER: begin
        if (!any_free) begin
          status_d = ST_FULL;
        end else begin
          reg_marks_d[free_idx] = 1'b1;
          reg_cnt_d             = reg_cnt_q + 1'b1;
          given_d               = SLOT_W'(free_idx);
        end
      end
      MODE_UNREGISTER: begin
        // Both marks are dropped even when the slot was never registered.
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          if (busy_marks_q[idx]) begin
            busy_marks_d[idx] = 1'b0;
            busy_cnt_d        = busy_cnt_q - 1'b1;
          end
          if (reg_marks_q[idx]) begin
            reg_marks_d[idx] = 1'b0;
            reg_cnt_d        = reg_cnt_q - 1'b1;
          end
        end
      end
      MODE_ADVISE: begin
        // The registration check comes before the advice value is looked at.
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (!reg_marks_q[idx]) begin
          status_d = ST_UNREG;
        end else begin
          case (advice_q)
            ADVICE_IDLE: begin
              if (busy_marks_q[idx]) begin
                busy_marks_d[idx] = 1'b0;
                busy_cnt_d        = busy_cnt_q - 1'b1;
              end
            end
            ADVICE_BUSY: begin
              if (!busy_marks_q[idx]) begin
                busy_marks_d[idx] = 1'b1;
                busy_cnt_d        = busy_cnt_q + 1'b1;
              end
            end
            default: begin
              status_d = ST_ADVICE;
            end
          endcase
        end
      end
      default: begin
        // The unused mode changes nothing and reports success.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_marks_q  <= '0;
      busy_marks_q <= '0;
      reg_cnt_q    <= '0;
      busy_cnt_q   <= '0;
    end else if (advance) begin
      reg_marks_q  <= reg_marks_d;
      busy_marks_q <= busy_marks_d;
      reg_cnt_q    <= reg_cnt_d;
      busy_cnt_q   <= busy_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. The counts shown are the low bits of the counts after the
  // step, which matters only when there are more slots than the field can show.
  // ---------------------------------------------------------------------------
  logic              out_valid_q, out_valid_d;
  status_e           status_q;
  logic [SLOT_W-1:0] given_q;
  logic [CNT_W-1:0]  busy_tot_q, reg_tot_q;

  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q   <= status_d;
      given_q    <= given_d;
      busy_tot_q <= busy_cnt_d;
      reg_tot_q  <= reg_cnt_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign assigned_slot_o    = given_q;
  assign busy_total_o       = TOTAL_W'(busy_tot_q);
  assign registered_total_o = TOTAL_W'(reg_tot_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Only a registered slot can be marked busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_marks_q & ~reg_marks_q) == '0)
    else $error("busy mark set on a slot that is not registered");

  // The counts stay in step with the marks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(reg_cnt_q) == 32'($countones(reg_marks_q)))
    else $error("registered count differs from registered marks");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(busy_cnt_q) == 32'($countones(busy_marks_q)))
    else $error("busy count differs from busy marks");

  // A processed item always leaves a result behind in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item produced no result");

endmodule : busy_vote_slot_tracker_core

`default_nettype wire

// ===== bench/busy_vote_slot_tracker_core_tb.sv =====
// Self-checking bench for busy_vote_slot_tracker_core: directed corner cases, filling to
// full, then random register, unregister and advise traffic with idling on both sides.
// Depends on bvst_pkg and busy_vote_slot_tracker_core only.
`timescale 1ns / 1ps

module busy_vote_slot_tracker_core_tb;
  import bvst_pkg::*;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned SLOT_MAX = (1 << SLOT_W) - 1;

  // One result item as the tracker should report it.
  typedef struct packed {
    status_e              status;
    logic [SLOT_W-1:0]    slot;
    logic [TOTAL_W-1:0]   busy_total;
    logic [TOTAL_W-1:0]   registered_total;
  } tracker_result_t;

  logic                 clk = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           mode_i;
  logic [SLOT_W-1:0]    slot_i;
  logic [1:0]           advice_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [2:0]           status_o;
  logic [SLOT_W-1:0]    assigned_slot_o;
  logic [TOTAL_W-1:0]   busy_total_o;
  logic [TOTAL_W-1:0]   registered_total_o;

  // Our own copy of the slot table, updated as each item is accepted.
  logic [SLOTS-1:0]     registered_marks;
  logic [SLOTS-1:0]     busy_marks;
  int unsigned          model_busy_cnt;
  int unsigned          model_reg_cnt;

  tracker_result_t      pending_results[$];
  tracker_result_t      oldest;
  int unsigned          mismatch_count = 0;
  // While set, neither side idles.
  logic                 quiet_phase = 1'b0;

  busy_vote_slot_tracker_core #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .slot_i             (slot_i),
    .advice_i           (advice_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .assigned_slot_o    (assigned_slot_o),
    .busy_total_o       (busy_total_o),
    .registered_total_o (registered_total_o)
  );

  always #4 clk = ~clk;

  // Result side stalls about one cycle in five, except in quiet phases.
  always @(posedge clk) begin
    if (!quiet_phase && $urandom_range(0, 99) < 20) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Applies one request to the table and returns the result it must produce.
  function automatic tracker_result_t apply_request(mode_e mode, logic [SLOT_W-1:0] slot,
                                                    logic [1:0] advice);
    tracker_result_t r;
    int unsigned free_slot;
    r.status = ST_OK;
    r.slot = slot;
    case (mode)
      MODE_REGISTER: begin
        free_slot = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!registered_marks[i]) free_slot = i;
        end
        if (free_slot == SLOTS) begin
          r.status = ST_FULL;
        end else begin
          registered_marks[free_slot] = 1'b1;
          model_reg_cnt++;
          r.slot = free_slot[SLOT_W-1:0];
        end
      end
      MODE_UNREGISTER: begin
        if (slot >= SLOTS) begin
          r.status = ST_RANGE;
        end else begin
          // Both marks are dropped whether or not the slot was registered.
          if (busy_marks[slot]) begin
            busy_marks[slot] = 1'b0;
            model_busy_cnt--;
          end
          if (registered_marks[slot]) begin
            registered_marks[slot] = 1'b0;
            model_reg_cnt--;
          end
        end
      end
      MODE_ADVISE: begin
        // Range, then registration, then the advice value itself.
        if (slot >= SLOTS) begin
          r.status = ST_RANGE;
        end else if (!registered_marks[slot]) begin
          r.status = ST_UNREG;
        end else if (advice == ADVICE_IDLE) begin
          if (busy_marks[slot]) begin
            busy_marks[slot] = 1'b0;
            model_busy_cnt--;
          end
        end else if (advice == ADVICE_BUSY) begin
          if (!busy_marks[slot]) begin
            busy_marks[slot] = 1'b1;
            model_busy_cnt++;
          end
        end else begin
          r.status = ST_ADVICE;
        end
      end
      default: begin
      end
    endcase
    r.busy_total = model_busy_cnt[TOTAL_W-1:0];
    r.registered_total = model_reg_cnt[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Every result item taken from the tracker is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0d slot %0d",
                 $time, status_o, assigned_slot_o);
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        compare_field("status", 32'(oldest.status), 32'(status_o));
        compare_field("assigned_slot", 32'(oldest.slot), 32'(assigned_slot_o));
        compare_field("busy_total", 32'(oldest.busy_total), 32'(busy_total_o));
        compare_field("registered_total", 32'(oldest.registered_total),
                      32'(registered_total_o));
      end
    end
  end

  // Offers one item, holding it until accepted. Valid is left high so that a following
  // item can go out back to back; here it is dropped only when a gap is taken.
  task automatic push_request(input mode_e mode, input logic [SLOT_W-1:0] slot,
                              input logic [1:0] advice);
    if (!quiet_phase && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    slot_i     <= slot;
    advice_i   <= advice;
    do @(posedge clk); while (!in_ready_o);
    pending_results.push_back(apply_request(mode, slot, advice));
  endtask

  // Drops valid and waits until every predicted result has been seen.
  task automatic wait_results_settled();
    in_valid_i <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [SLOT_W-1:0] pick_slot();
    int unsigned r;
    logic [SLOT_W-1:0] s;
    r = $urandom_range(0, 99);
    if (r < 8 && SLOTS <= SLOT_MAX) begin
      s = SLOT_W'($urandom_range(SLOTS, SLOT_MAX));
    end else if (r < 75 && model_reg_cnt != 0) begin
      // Aim at a live slot so that advise and unregister do real work.
      do s = SLOT_W'($urandom_range(0, SLOTS - 1)); while (!registered_marks[s]);
    end else begin
      s = SLOT_W'($urandom_range(0, SLOTS - 1));
    end
    return s;
  endfunction

  function automatic logic [1:0] pick_advice();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return ADVICE_IDLE;
    if (r < 90) return ADVICE_BUSY;
    return 2'($urandom_range(2, 3));
  endfunction

  // Reset state, both advice values, the bad-advice and unregistered checks and
  // their order, range limits, unregister of an unregistered and a busy slot, and the unused mode.
  task automatic test_directed_cases();
    push_request(MODE_REGISTER, SLOT_W'(SLOT_MAX), 2'd3);
    push_request(MODE_REGISTER, 8'd0, ADVICE_IDLE);
    push_request(MODE_REGISTER, 8'd17, ADVICE_BUSY);
    push_request(MODE_ADVISE, 8'd1, ADVICE_BUSY);
    push_request(MODE_ADVISE, 8'd1, ADVICE_BUSY);
    push_request(MODE_ADVISE, 8'd2, ADVICE_IDLE);
    push_request(MODE_ADVISE, 8'd1, 2'd2);
    push_request(MODE_ADVISE, 8'd1, 2'd3);
    push_request(MODE_ADVISE, 8'd5, 2'd3);
    push_request(MODE_ADVISE, SLOT_W'(SLOTS), ADVICE_BUSY);
    push_request(MODE_ADVISE, SLOT_W'(SLOT_MAX), ADVICE_IDLE);
    push_request(MODE_UNREGISTER, SLOT_W'(SLOTS), ADVICE_IDLE);
    push_request(MODE_UNREGISTER, SLOT_W'(SLOT_MAX), ADVICE_IDLE);
    push_request(MODE_UNREGISTER, 8'd7, ADVICE_IDLE);
    push_request(MODE_UNREGISTER, 8'd1, ADVICE_IDLE);
    push_request(MODE_REGISTER, 8'd0, ADVICE_IDLE);
    push_request(MODE_ADVISE, SLOT_W'(SLOTS - 1), ADVICE_BUSY);
    push_request(MODE_NOP, SLOT_W'(SLOT_MAX), 2'd3);
    push_request(MODE_NOP, 8'd0, ADVICE_IDLE);
    push_request(MODE_ADVISE, 8'd0, ADVICE_BUSY);
    push_request(MODE_ADVISE, 8'd0, ADVICE_IDLE);
  endtask

  // Registers until no slot is free, then checks the full report and slot reuse.
  task automatic test_fill_to_full();
    while (model_reg_cnt < SLOTS) begin
      push_request(MODE_REGISTER, SLOT_W'($urandom_range(0, SLOT_MAX)),
                   2'($urandom_range(0, 3)));
    end
    push_request(MODE_ADVISE, SLOT_W'(SLOTS - 1), ADVICE_BUSY);
    push_request(MODE_REGISTER, SLOT_W'(SLOT_MAX), ADVICE_IDLE);
    push_request(MODE_REGISTER, SLOT_W'($urandom_range(0, SLOT_MAX)),
                 2'($urandom_range(0, 3)));
    push_request(MODE_UNREGISTER, 8'd37, ADVICE_IDLE);
    push_request(MODE_REGISTER, 8'd0, ADVICE_IDLE);
    push_request(MODE_REGISTER, 8'd0, ADVICE_IDLE);
  endtask

  // Random mix; the weights steer the table toward full or toward empty.
  task automatic test_random_traffic(input int unsigned count, input int unsigned reg_pct,
                                     input int unsigned unreg_pct);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < reg_pct) begin
        push_request(MODE_REGISTER, SLOT_W'($urandom_range(0, SLOT_MAX)),
                     2'($urandom_range(0, 3)));
      end else if (r < reg_pct + unreg_pct) begin
        push_request(MODE_UNREGISTER, pick_slot(), 2'($urandom_range(0, 3)));
      end else if (r < 95) begin
        push_request(MODE_ADVISE, pick_slot(), pick_advice());
      end else begin
        push_request(MODE_NOP, SLOT_W'($urandom_range(0, SLOT_MAX)),
                     2'($urandom_range(0, 3)));
      end
    end
  endtask

  // The sender holds off until the tracker has delivered everything, then resumes.
  task automatic test_drain_pause();
    test_random_traffic(30, 35, 25);
    wait_results_settled();
    test_random_traffic(30, 35, 25);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    mode_i      <= MODE_NOP;
    slot_i      <= '0;
    advice_i    <= ADVICE_IDLE;
    registered_marks = '0;
    busy_marks = '0;
    model_busy_cnt = 0;
    model_reg_cnt = 0;
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_fill_to_full();
    quiet_phase = 1'b1;
    test_random_traffic(250, 45, 15);
    quiet_phase = 1'b0;
    test_drain_pause();
    test_random_traffic(250, 30, 25);
    test_random_traffic(100, 15, 45);

    wait_results_settled();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bvst_pkg.sv
rtl/busy_vote_slot_tracker_core.sv
bench/busy_vote_slot_tracker_core_tb.sv
